### sv/lmss_pkg.sv
package lmss_pkg;

  localparam int MAX_WINDOW_DEF = 15;
  localparam int MAX_WIDTH_DEF  = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic [1:0] FUNC_LOAD_PATCH = 2'd0;
  localparam logic [1:0] FUNC_LOAD_BAND  = 2'd1;
  localparam logic [1:0] FUNC_SEARCH     = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  pixel;
    logic [3:0]  row_index;
    logic [9:0]  col_index;
    logic [9:0]  feature_x;
    logic [11:0] feature_y;
  } item_t;

  typedef struct packed {
    logic signed [10:0] match_x;
    logic [15:0]        min_sad_sum;
    logic [7:0]         window_pixels;
  } result_t;

  // control flags that travel with each column request along the cell row
  typedef struct packed {
    logic valid;
    logic last;  // last column of a candidate window
    logic fin;   // last column of the whole search
  } cell_ctl_t;

endpackage

### sv/lmss_item_if.sv
interface lmss_item_if;
  logic                valid;
  logic                ready;
  lmss_pkg::item_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/lmss_result_if.sv
interface lmss_result_if;
  logic                valid;
  logic                ready;
  lmss_pkg::result_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/lmss_cell.sv
module lmss_cell #(
  parameter int ROW        = 0,
  parameter int MAX_WINDOW = lmss_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = lmss_pkg::MAX_WIDTH_DEF,
  parameter int PC_W       = $clog2(MAX_WINDOW),
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int HW         = $clog2(MAX_WINDOW / 2 + 1),
  parameter int SUM_W      = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  patch_we,
  input  logic                  band_we,
  input  logic [PC_W-1:0]       wr_pcol,
  input  logic [COL_W-1:0]      wr_bcol,
  input  logic [7:0]            wr_pixel,
  input  logic [HW-1:0]         h,
  input  lmss_pkg::cell_ctl_t   in_ctl,
  input  logic [PC_W-1:0]       in_pcol,
  input  logic [COL_W-1:0]      in_bcol,
  input  logic [SUM_W-1:0]      in_sum,
  output lmss_pkg::cell_ctl_t   out_ctl,
  output logic [PC_W-1:0]       out_pcol,
  output logic [COL_W-1:0]      out_bcol,
  output logic [SUM_W-1:0]      out_sum
);
  import lmss_pkg::*;

  localparam int CTR = MAX_WINDOW / 2;

  logic [7:0]       patch [MAX_WINDOW];
  logic [7:0]       band  [MAX_WIDTH];
  logic [7:0]       patch_q;
  logic [7:0]       band_q;
  cell_ctl_t        ctl_a;
  logic [PC_W-1:0]  pcol_a;
  logic [COL_W-1:0] bcol_a;
  logic [SUM_W-1:0] sum_a;
  logic             active;
  logic [7:0]       diff;

  // this row takes part only when it lies inside the clipped window
  assign active = (ROW + int'(h) >= CTR) && (ROW <= CTR + int'(h));
  assign diff   = (patch_q > band_q) ? (patch_q - band_q) : (band_q - patch_q);

  always_ff @(posedge clk) begin
    if (patch_we) begin
      patch[wr_pcol] <= wr_pixel;
    end
    patch_q <= patch[in_pcol];
  end

  always_ff @(posedge clk) begin
    if (band_we) begin
      band[wr_bcol] <= wr_pixel;
    end
    band_q <= band[in_bcol];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      out_ctl <= '0;
    end else begin
      ctl_a   <= in_ctl;
      out_ctl <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    pcol_a   <= in_pcol;
    bcol_a   <= in_bcol;
    sum_a    <= in_sum;
    out_pcol <= pcol_a;
    out_bcol <= bcol_a;
    out_sum  <= active ? (sum_a + SUM_W'(diff)) : sum_a;
  end

endmodule

### sv/line_min_sad_search_unit.sv
// Load items: a new item every cycle while no search is in progress.
// Search items: one column request per cycle over (2h+1) columns for each
// candidate position; each request then passes through the registers of every
// cell in the row, and the done state loads the result register; an invalid
// window goes from idle straight to the done state.
// The next item is taken once the search result sits in the output register.
// Reset (synchronous, rst high) clears control and configuration; the patch
// and band stores keep their contents.
module line_min_sad_search_unit #(
  parameter int MAX_WINDOW = lmss_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = lmss_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmss_pkg::CFG_DATA_W-1:0]   cfg_data,
  lmss_item_if.sink                         items,
  lmss_result_if.source                     results
);
  import lmss_pkg::*;

  localparam int CTR   = MAX_WINDOW / 2;
  localparam int PC_W  = $clog2(MAX_WINDOW);
  localparam int HW    = $clog2(CTR + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int NPX_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [3:0]  window_size;
  logic        search_left;
  logic [10:0] image_width;
  logic [12:0] image_height;

  logic [HW-1:0]    h_reg;
  logic [COL_W-1:0] c_reg;
  logic [PC_W-1:0]  k_reg;
  logic [COL_W-1:0] cur_c;
  logic [COL_W-1:0] best;
  logic             found;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] minsad;
  logic [NPX_W-1:0] npx_reg;

  logic             accept;
  logic [15:0]      w_eff;
  logic [HW-1:0]    clip_h;
  logic             clip_ok;
  logic [PC_W-1:0]  side;
  logic [NPX_W-1:0] npx;
  logic [SUM_W-1:0] bound;
  logic             cand_last;
  logic [SUM_W-1:0] win_sum;

  cell_ctl_t        ctl_w  [MAX_WINDOW+1];
  logic [PC_W-1:0]  pcol_w [MAX_WINDOW+1];
  logic [COL_W-1:0] bcol_w [MAX_WINDOW+1];
  logic [SUM_W-1:0] sum_w  [MAX_WINDOW+1];

  logic                  load_patch;
  logic                  load_band;
  logic [MAX_WINDOW-1:0] row_sel;

  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= 4'd7;
      search_left  <= 1'b0;
      image_width  <= 11'd640;
      image_height <= 13'd480;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW_SIZE:  window_size  <= cfg_data[3:0];
        REG_SEARCH_LEFT:  search_left  <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (32'(image_width) < MAX_WIDTH) ? 16'(image_width) : 16'(MAX_WIDTH);

  // clip the half window to the image borders, then to the patch size
  always_comb begin
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [15:0] ws;
    logic signed [15:0] hs;
    logic signed [15:0] hv;
    xs = signed'(16'(items.payload.feature_x));
    ys = signed'(16'(items.payload.feature_y));
    ws = signed'(w_eff);
    hs = signed'(16'(image_height));
    hv = signed'(16'(window_size[3:1]));
    if (xs - hv < 0) hv = xs;
    if (xs + hv >= ws) hv = ws - 16'sd1 - xs;
    if (ys - hv < 0) hv = ys;
    if (ys + hv >= hs) hv = hs - 16'sd1 - ys;
    if (hv > 16'(CTR)) hv = 16'(CTR);
    clip_ok = window_size[0] && (hv > 0);
    clip_h  = HW'(hv);
  end

  assign side  = PC_W'({clip_h, 1'b1});
  assign npx   = NPX_W'(side) * NPX_W'(side);
  assign bound = (SUM_W'(npx) << 8) - SUM_W'(npx);

  // store writes go straight to the cell of the addressed row
  assign load_patch = accept && (items.payload.func == FUNC_LOAD_PATCH)
                      && (32'(items.payload.row_index) < MAX_WINDOW)
                      && (32'(items.payload.col_index) < MAX_WINDOW);
  assign load_band  = accept && (items.payload.func == FUNC_LOAD_BAND)
                      && (32'(items.payload.row_index) < MAX_WINDOW)
                      && (32'(items.payload.col_index) < MAX_WIDTH);

  always_comb begin
    row_sel = '0;
    for (int r = 0; r < MAX_WINDOW; r++) begin
      row_sel[r] = (32'(items.payload.row_index) == r);
    end
  end

  // column request generator
  assign cand_last = search_left ? (c_reg == COL_W'(h_reg))
                                 : (16'(c_reg) + 16'(h_reg) + 16'd1 == w_eff);

  always_comb begin
    ctl_w[0].valid = (state == S_ISSUE);
    ctl_w[0].last  = (k_reg == PC_W'({h_reg, 1'b0}));
    ctl_w[0].fin   = ctl_w[0].last && cand_last;
    pcol_w[0]      = PC_W'(CTR) - PC_W'(h_reg) + k_reg;
    bcol_w[0]      = c_reg - COL_W'(h_reg) + COL_W'(k_reg);
    sum_w[0]       = '0;
  end

  for (genvar r = 0; r < MAX_WINDOW; r++) begin : g_cell
    lmss_cell #(
      .ROW        (r),
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_WIDTH  (MAX_WIDTH),
      .PC_W       (PC_W),
      .COL_W      (COL_W),
      .HW         (HW),
      .SUM_W      (SUM_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .patch_we (load_patch && row_sel[r]),
      .band_we  (load_band && row_sel[r]),
      .wr_pcol  (PC_W'(items.payload.col_index)),
      .wr_bcol  (COL_W'(items.payload.col_index)),
      .wr_pixel (items.payload.pixel),
      .h        (h_reg),
      .in_ctl   (ctl_w[r]),
      .in_pcol  (pcol_w[r]),
      .in_bcol  (bcol_w[r]),
      .in_sum   (sum_w[r]),
      .out_ctl  (ctl_w[r+1]),
      .out_pcol (pcol_w[r+1]),
      .out_bcol (bcol_w[r+1]),
      .out_sum  (sum_w[r+1])
    );
  end

  assign win_sum = acc + sum_w[MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!results.valid || results.ready)) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && items.payload.func == FUNC_SEARCH) begin
            state <= clip_ok ? S_ISSUE : S_DONE;
          end
        end
        S_ISSUE: begin
          if (ctl_w[0].fin) state <= S_WAIT;
        end
        S_WAIT: begin
          if (ctl_w[MAX_WINDOW].valid && ctl_w[MAX_WINDOW].fin) state <= S_DONE;
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath of the search: set up on accept, advance while issuing and as sums leave the cell row
  always_ff @(posedge clk) begin
    if (accept && items.payload.func == FUNC_SEARCH) begin
      h_reg   <= clip_h;
      c_reg   <= COL_W'(items.payload.feature_x);
      cur_c   <= COL_W'(items.payload.feature_x);
      k_reg   <= '0;
      acc     <= '0;
      found   <= 1'b0;
      minsad  <= clip_ok ? bound : '0;
      npx_reg <= clip_ok ? npx : '0;
    end else begin
      if (state == S_ISSUE) begin
        if (ctl_w[0].last) begin
          k_reg <= '0;
          c_reg <= search_left ? (c_reg - COL_W'(1)) : (c_reg + COL_W'(1));
        end else begin
          k_reg <= k_reg + PC_W'(1);
        end
      end
      if (ctl_w[MAX_WINDOW].valid) begin
        if (ctl_w[MAX_WINDOW].last) begin
          acc   <= '0;
          cur_c <= search_left ? (cur_c - COL_W'(1)) : (cur_c + COL_W'(1));
          if (win_sum < minsad) begin
            minsad <= win_sum;
            best   <= cur_c;
            found  <= 1'b1;
          end
        end else begin
          acc <= win_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!results.valid || results.ready)) begin
      results.payload.match_x       <= found ? signed'(11'(best)) : -11'sd1;
      results.payload.min_sad_sum   <= (32'(minsad) > 32'hFFFF) ? 16'hFFFF : 16'(minsad);
      results.payload.window_pixels <= (32'(npx_reg) > 32'hFF) ? 8'hFF : 8'(npx_reg);
    end
  end

  a_no_request_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ctl_w[0].valid)
    else $error("column request issued outside a search");

  a_fin_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    (ctl_w[MAX_WINDOW].valid && ctl_w[MAX_WINDOW].fin) |-> state == S_WAIT)
    else $error("end of search seen outside the wait state");

  a_half_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |-> h_reg != '0)
    else $error("search running with an empty window");

  a_min_never_rises: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ISSUE || state == S_WAIT) && ($past(state) == S_ISSUE
      || $past(state) == S_WAIT)) |-> minsad <= $past(minsad))
    else $error("best sum grew during a search");

endmodule

### verif/line_min_sad_search_unit_checker.sv
`timescale 1ns / 1ps

module line_min_sad_search_unit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  input  logic                            item_ready,
  input  lmss_pkg::item_t                 item_data,
  input  logic                            res_valid,
  input  logic                            res_ready,
  input  lmss_pkg::result_t               res_data,
  output int                              errors,
  output int                              pending
);
  import lmss_pkg::*;

  localparam int PATCH_N = MAX_WINDOW_DEF;
  localparam int BAND_W  = MAX_WIDTH_DEF;
  localparam int MID     = PATCH_N / 2;

  logic [7:0]  patch_px [PATCH_N*PATCH_N];
  logic [7:0]  band_px  [PATCH_N*BAND_W];
  logic [3:0]  win_side;
  logic        walk_left;
  logic [10:0] img_width;
  logic [12:0] img_height;
  result_t     match_q [$];

  initial errors = 0;
  initial pending = 0;

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // clipped half window for the current settings; 0 or less means no valid window
  function automatic int half_window(int x, int y);
    int w, h;
    w = (img_width < BAND_W) ? int'(img_width) : BAND_W;
    if (!win_side[0]) return 0;
    h = int'(win_side) / 2;
    if (x - h < 0) h = x;
    if (x + h >= w) h = w - 1 - x;
    if (y - h < 0) h = y;
    if (y + h >= int'(img_height)) h = int'(img_height) - 1 - y;
    if (h > MID) h = MID;
    return h;
  endfunction

  function automatic int unsigned block_sad(int h, int c);
    int unsigned sum;
    int p, q;
    sum = 0;
    for (int dr = -h; dr <= h; dr++)
      for (int dc = -h; dc <= h; dc++) begin
        p = int'(patch_px[(MID + dr) * PATCH_N + MID + dc]);
        q = int'(band_px[(MID + dr) * BAND_W + c + dc]);
        sum += (p > q) ? p - q : q - p;
      end
    return sum;
  endfunction

  function automatic result_t best_column(item_t it);
    result_t r;
    int w, h, x, best;
    int unsigned npx, minsad, s;
    x = int'(it.feature_x);
    w = (img_width < BAND_W) ? int'(img_width) : BAND_W;
    h = half_window(x, int'(it.feature_y));
    if (h <= 0) begin
      r.match_x = -11'sd1;
      r.min_sad_sum = '0;
      r.window_pixels = '0;
      return r;
    end
    npx = (2 * h + 1) * (2 * h + 1);
    minsad = 255 * npx;
    best = -1;
    if (walk_left) begin
      for (int c = x; c >= h; c--) begin
        s = block_sad(h, c);
        if (s < minsad) begin
          minsad = s;
          best = c;
        end
      end
    end else begin
      for (int c = x; c < w - h; c++) begin
        s = block_sad(h, c);
        if (s < minsad) begin
          minsad = s;
          best = c;
        end
      end
    end
    r.match_x = best[10:0];
    r.min_sad_sum = (minsad > 65535) ? 16'hFFFF : minsad[15:0];
    r.window_pixels = (npx > 255) ? 8'hFF : npx[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      win_side <= 4'd7;
      walk_left <= 1'b0;
      img_width <= 11'd640;
      img_height <= 13'd480;
      match_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WINDOW_SIZE: win_side <= cfg_data[3:0];
          REG_SEARCH_LEFT: walk_left <= cfg_data[0];
          REG_IMAGE_WIDTH: img_width <= cfg_data[10:0];
          REG_IMAGE_HEIGHT: img_height <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (match_q.size() == 0) begin
          report("unrequested result match_x", int'(res_data.match_x), 0);
        end else begin
          want = match_q.pop_front();
          if (res_data.match_x != want.match_x)
            report("match_x", int'(res_data.match_x), int'(want.match_x));
          if (res_data.min_sad_sum != want.min_sad_sum)
            report("min_sad_sum", int'(res_data.min_sad_sum), int'(want.min_sad_sum));
          if (res_data.window_pixels != want.window_pixels)
            report("window_pixels", int'(res_data.window_pixels),
                   int'(want.window_pixels));
        end
      end
      if (item_valid && item_ready) begin
        case (item_data.func)
          FUNC_LOAD_PATCH:
            if (item_data.row_index < PATCH_N && item_data.col_index < PATCH_N)
              patch_px[item_data.row_index * PATCH_N + item_data.col_index] = item_data.pixel;
          FUNC_LOAD_BAND:
            if (item_data.row_index < PATCH_N)
              band_px[item_data.row_index * BAND_W + item_data.col_index] = item_data.pixel;
          FUNC_SEARCH: match_q = {match_q, best_column(item_data)};
          default: ;
        endcase
      end
    end
    pending = match_q.size();
  end

endmodule

### verif/line_min_sad_search_unit_tb.sv
`timescale 1ns / 1ps

module line_min_sad_search_unit_tb;
  import lmss_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int BAND_COLS = 32;
  localparam int N_PHASES = 8;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors, pending;
  int                    cycles = 0;
  int                    regime = 0;
  bit                    hold_start = 0;
  bit                    band_written [MAX_WINDOW_DEF][MAX_WIDTH_DEF];
  bit                    cur_left;
  int                    cur_width;

  lmss_item_if   items ();
  lmss_result_if results ();

  line_min_sad_search_unit uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .items(items.sink), .results(results.source)
  );

  line_min_sad_search_unit_checker chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item_valid(items.valid), .item_ready(items.ready),
    .item_data(items.payload), .res_valid(results.valid), .res_ready(results.ready),
    .res_data(results.payload), .errors(errors), .pending(pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    static int hold_left = 0;
    static bit hold_done = 0;
    if (hold_start && !hold_done) begin
      hold_left = 600;
      hold_done = 1;
    end
    if (rst) results.ready <= 1'b0;
    else if (hold_left > 0) begin
      results.ready <= 1'b0;
      hold_left--;
    end else if (regime == 0) results.ready <= ($urandom_range(0, 99) >= 71);
    else if (regime == 1) results.ready <= ($urandom_range(0, 99) >= 29);
    else results.ready <= 1'b1;
  end

  // called on a falling edge; returns on a falling edge after acceptance
  task automatic send(item_t it);
    int idle_pct;
    idle_pct = (regime == 0) ? 29 : (regime == 1) ? 71 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid <= 1'b1;
    items.payload <= it;
    do @(posedge clk); while (!items.ready);
    @(negedge clk);
    if (it.func == FUNC_LOAD_BAND && it.row_index < MAX_WINDOW_DEF)
      band_written[it.row_index][it.col_index] = 1;
  endtask

  function automatic item_t rand_item(logic [1:0] f);
    item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.func = f;
    return it;
  endfunction

  task automatic load(logic [1:0] f, int r, int c, int px);
    item_t it;
    it = rand_item(f);
    it.row_index = 4'(r);
    it.col_index = 10'(c);
    it.pixel = 8'(px);
    send(it);
  endtask

  task automatic search(int x, int y);
    item_t it;
    it = rand_item(FUNC_SEARCH);
    it.feature_x = 10'(x);
    it.feature_y = 12'(y);
    send(it);
  endtask

  // a search must only read band entries that were loaded
  function automatic bit band_covers(int x, int y);
    int h, lo, hi, w;
    h = chk.half_window(x, y);
    if (h <= 0) return 1;
    w = (cur_width < MAX_WIDTH_DEF) ? cur_width : MAX_WIDTH_DEF;
    lo = cur_left ? 0 : x - h;
    hi = cur_left ? x + h : w - 1;
    if (cur_left && x < h) return 1;
    if (!cur_left && x >= w - h) return 1;
    for (int r = MAX_WINDOW_DEF / 2 - h; r <= MAX_WINDOW_DEF / 2 + h; r++)
      for (int c = lo; c <= hi; c++)
        if (!band_written[r][c]) return 0;
    return 1;
  endfunction

  task automatic settle();
    items.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic configure(int ws, int left, int width, int height);
    items.valid <= 1'b0;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data <= CFG_DATA_W'(ws);
    @(negedge clk);
    cfg_index <= REG_SEARCH_LEFT;
    cfg_data <= CFG_DATA_W'(left);
    @(negedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= CFG_DATA_W'(width);
    @(negedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= CFG_DATA_W'(height);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    cur_left = (left != 0);
    cur_width = width;
  endtask

  initial begin
    int ws_tab [N_PHASES] = '{3, 15, 9, 8, 5, 15, 1, 11};
    int lf_tab [N_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
    int wd_tab [N_PHASES] = '{16, 1024, 32, 20, 2047, 17, 24, 28};
    int ht_tab [N_PHASES] = '{16, 4096, 100, 30, 8191, 2000, 16, 40};
    int per_phase, x, y, tries, pick;
    items.valid = 1'b0;
    items.payload = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    regime = 2;

    // dark patch against a bright band: no column can beat the bound
    for (int r = 0; r < MAX_WINDOW_DEF; r++)
      for (int c = 0; c < MAX_WINDOW_DEF; c++) load(FUNC_LOAD_PATCH, r, c, 0);
    for (int r = 0; r < MAX_WINDOW_DEF; r++)
      for (int c = 0; c < BAND_COLS; c++) load(FUNC_LOAD_BAND, r, c, 255);

    configure(7, 0, 16, 16);
    search(8, 8);
    search(0, 8);
    search(15, 8);
    search(8, 0);
    search(8, 15);
    search(1023, 4095);
    load(FUNC_LOAD_PATCH, 15, 3, 17);
    load(FUNC_LOAD_PATCH, 3, 15, 17);
    load(FUNC_LOAD_BAND, 15, 1023, 99);
    send(rand_item(FUNC_UNUSED));
    load(FUNC_LOAD_BAND, 7, 10, 0);
    load(FUNC_LOAD_BAND, 7, 12, 0);
    search(5, 7);
    settle();
    configure(4, 1, 16, 16);
    search(8, 8);
    search(3, 3);
    settle();

    // the preload and directed requests above come to about 720
    per_phase = (1350 - 720) / N_PHASES;
    for (int p = 0; p < N_PHASES; p++) begin
      regime = (p < 3) ? 0 : (p < 6) ? 1 : 2;
      configure(ws_tab[p], lf_tab[p], wd_tab[p], ht_tab[p]);
      if (p == 4) hold_start = 1;
      for (int i = 0; i < per_phase; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          load(FUNC_LOAD_BAND, $urandom_range(0, 15),
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, BAND_COLS - 1),
               $urandom_range(0, 255));
        end else if (pick < 55) begin
          load(FUNC_LOAD_PATCH, $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 255));
        end else if (pick < 59) begin
          send(rand_item(FUNC_UNUSED));
        end else begin
          tries = 0;
          do begin
            x = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
            y = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, ht_tab[p] % 4096);
            tries++;
          end while (!band_covers(x, y) && tries < 30);
          if (!band_covers(x, y)) x = 1023;
          search(x, y);
        end
      end
      settle();
    end

    repeat (100) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
